// ===== hdl/srf_pkg.sv =====
package srf_pkg;

    localparam int SampleWidth = 32;
    localparam int DiffWidth = SampleWidth + 1;
    localparam int CountWidth = 16;
    localparam int WarnWidth = CountWidth + 1;
    localparam int LimitWidth = 31;

    typedef enum logic [1:0] {
        VERDICT_ACCEPT  = 2'd0,
        VERDICT_REJECT  = 2'd1,
        VERDICT_WARNING = 2'd2
    } verdict_t;

    localparam logic [1:0] REG_ACCEPT_COUNT_LIMIT   = 2'd0;
    localparam logic [1:0] REG_DISTANCE_LIMIT       = 2'd1;
    localparam logic [1:0] REG_STEP_AMPLITUDE_LIMIT = 2'd2;
    localparam logic [1:0] REG_WARNING_COUNT_LIMIT  = 2'd3;

endpackage

// ===== hdl/spike_rejection_filter.sv =====
// Spike rejection filter for a stream of signed Q16.16 samples. Each input beat carries one
// sample and produces exactly one output beat holding either the sample itself or the last
// accepted value, with a verdict in m_tuser (0 accepted, 1 rejected as a spike, 2 warning
// after too many consecutive rejects). A sample is rejected when its distance from the last
// accepted value exceeds distance_limit while the acceptance counter is below
// accept_count_limit; a run of rejects whose successive samples stay within
// step_amplitude_limit lets a genuine step through once that limit is reached. The block
// takes one beat per clock cycle unless stalled and returns its result in the next cycle
// from a single output register; s_tready is low only while that register is full and
// m_tready is low. The four limits are written through the APB port at byte addresses
// 0, 4, 8 and 12, all reset to zero, and should be changed only while no beat is in flight.
module spike_rejection_filter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] filtered_value
    output logic [1:0]  m_tuser,   // [1:0] verdict
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import srf_pkg::*;

    logic [CountWidth-1:0]  accept_count_limit_reg;
    logic [LimitWidth-1:0]  distance_limit_reg;
    logic [LimitWidth-1:0]  step_amplitude_limit_reg;
    logic [CountWidth-1:0]  warning_count_limit_reg;

    logic [SampleWidth-1:0] held_accepted_reg, held_accepted_next;
    logic [SampleWidth-1:0] last_rejected_reg, last_rejected_next;
    logic [CountWidth-1:0]  accept_counter_reg, accept_counter_next;
    logic [WarnWidth-1:0]   warning_counter_reg, warning_counter_next;

    logic                   m_tvalid_reg;
    logic [SampleWidth-1:0] m_tdata_reg, m_tdata_next;
    verdict_t               m_tuser_reg, m_tuser_next;

    logic                   s_accept;
    logic                   cfg_write;
    logic [DiffWidth-1:0]   held_diff, held_mag;
    logic [DiffWidth-1:0]   step_diff, step_mag;
    logic                   held_beyond, step_beyond, reject;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    always_comb begin
        unique case (paddr[3:2])
            REG_ACCEPT_COUNT_LIMIT:   prdata = {16'd0, accept_count_limit_reg};
            REG_DISTANCE_LIMIT:       prdata = {1'b0, distance_limit_reg};
            REG_STEP_AMPLITUDE_LIMIT: prdata = {1'b0, step_amplitude_limit_reg};
            REG_WARNING_COUNT_LIMIT:  prdata = {16'd0, warning_count_limit_reg};
            default:                  prdata = '0;
        endcase
    end

    always_comb begin
        held_diff   = {s_tdata[31], s_tdata} - {held_accepted_reg[31], held_accepted_reg};
        held_mag    = held_diff[DiffWidth-1] ? (~held_diff + 1'b1) : held_diff;
        held_beyond = held_mag > {2'b00, distance_limit_reg};
        step_diff   = {s_tdata[31], s_tdata} - {last_rejected_reg[31], last_rejected_reg};
        step_mag    = step_diff[DiffWidth-1] ? (~step_diff + 1'b1) : step_diff;
        step_beyond = step_mag > {2'b00, step_amplitude_limit_reg};
        reject      = held_beyond && (accept_counter_reg < accept_count_limit_reg);

        if (reject) begin
            accept_counter_next  = step_beyond ? '0 : accept_counter_reg + 1'b1;
            warning_counter_next = warning_counter_reg + 1'b1;
            held_accepted_next   = held_accepted_reg;
            last_rejected_next   = s_tdata;
            m_tdata_next         = held_accepted_reg;
            m_tuser_next         = VERDICT_REJECT;
        end else begin
            accept_counter_next  = '0;
            warning_counter_next = '0;
            held_accepted_next   = s_tdata;
            last_rejected_next   = s_tdata;
            m_tdata_next         = s_tdata;
            m_tuser_next         = VERDICT_ACCEPT;
        end

        if (warning_counter_next > {1'b0, warning_count_limit_reg}) begin
            warning_counter_next = '0;
            m_tuser_next         = VERDICT_WARNING;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accept_count_limit_reg   <= '0;
            distance_limit_reg       <= '0;
            step_amplitude_limit_reg <= '0;
            warning_count_limit_reg  <= '0;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_ACCEPT_COUNT_LIMIT:   accept_count_limit_reg   <= pwdata[CountWidth-1:0];
                REG_DISTANCE_LIMIT:       distance_limit_reg       <= pwdata[LimitWidth-1:0];
                REG_STEP_AMPLITUDE_LIMIT: step_amplitude_limit_reg <= pwdata[LimitWidth-1:0];
                REG_WARNING_COUNT_LIMIT:  warning_count_limit_reg  <= pwdata[CountWidth-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_accepted_reg   <= '0;
            last_rejected_reg   <= '0;
            accept_counter_reg  <= '0;
            warning_counter_reg <= '0;
            m_tvalid_reg        <= 1'b0;
        end else begin
            if (s_accept) begin
                held_accepted_reg   <= held_accepted_next;
                last_rejected_reg   <= last_rejected_next;
                accept_counter_reg  <= accept_counter_next;
                warning_counter_reg <= warning_counter_next;
                m_tvalid_reg        <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg        <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

`ifndef NO_ASSERTIONS
    // Every verdict leaves the held value equal to the value just produced.
    a_output_matches_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata == held_accepted_reg)
        else $error("output value differs from held accepted value");

    // An accepted sample resets the reject tracking to the same level.
    a_accept_aligns_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == VERDICT_ACCEPT |->
            last_rejected_reg == held_accepted_reg && accept_counter_reg == '0)
        else $error("accepted beat left inconsistent reject state");

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_tvalid)
        else $error("accepted beat produced no result");

    a_warning_clears_counter: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == VERDICT_WARNING |-> warning_counter_reg == '0)
        else $error("warning issued without clearing its counter");

    a_warning_counter_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        warning_counter_reg <= {1'b1, {CountWidth{1'b0}}})
        else $error("warning counter out of range");
`endif

endmodule

// ===== bench/tb_spike_rejection_filter.sv =====
`timescale 1ns / 1ps

module tb_spike_rejection_filter;
    import srf_pkg::*;

    localparam int CycleLimit = 400_000;
    localparam int StallCycles = 60;

    typedef struct {
        logic [31:0] value;
        verdict_t    verdict;
    } filter_out_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;       // [31:0] sample
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;            // [31:0] filtered_value
    logic [1:0]  m_tuser;            // [1:0] verdict
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [15:0] cfg_accept_limit = '0;
    logic [30:0] cfg_threshold = '0;
    logic [30:0] cfg_step_limit = '0;
    logic [15:0] cfg_warn_limit = '0;

    logic [31:0] held_value = '0;
    logic [31:0] last_spike = '0;
    logic [15:0] consistent_count = '0;
    logic [16:0] reject_run = '0;

    filter_out_t expected_outputs[$];
    filter_out_t head;

    int  fail_count = 0;
    int  samples_sent = 0;
    int  results_checked = 0;
    int  settings_used = 0;
    int  verdict_count[4] = '{0, 0, 0, 0};
    int  cycle_count = 0;
    bit  calm = 1'b0;
    int  stall_requests = 0;
    int  stalls_started = 0;
    int  hold_left = 0;

    spike_rejection_filter dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("tb_spike_rejection_filter failed");
            $finish;
        end
    end

    function automatic bit far_apart(logic [31:0] a, logic [31:0] b, logic [30:0] limit);
        logic signed [32:0] diff;
        logic [32:0]        mag;
        diff = $signed({a[31], a}) - $signed({b[31], b});
        mag = diff[32] ? 33'(-diff) : 33'(diff);
        return mag > {2'b00, limit};
    endfunction

    function automatic void predict_filter(logic [31:0] x);
        filter_out_t out;
        if (far_apart(x, held_value, cfg_threshold) && consistent_count < cfg_accept_limit) begin
            consistent_count = consistent_count + 1'b1;
            reject_run = reject_run + 1'b1;
            if (far_apart(x, last_spike, cfg_step_limit)) begin
                consistent_count = '0;
            end
            last_spike = x;
            out.value = held_value;
            out.verdict = VERDICT_REJECT;
        end else begin
            consistent_count = '0;
            reject_run = '0;
            held_value = x;
            last_spike = x;
            out.value = x;
            out.verdict = VERDICT_ACCEPT;
        end
        if (reject_run > {1'b0, cfg_warn_limit}) begin
            reject_run = '0;
            out.verdict = VERDICT_WARNING;
        end
        expected_outputs.push_back(out);
    endfunction

    function automatic logic [31:0] signed_offset(logic [30:0] limit);
        logic [31:0] off;
        off = $urandom_range(0, {1'b0, limit});
        return $urandom_range(0, 1) ? -off : off;
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_checked++;
                verdict_count[m_tuser]++;
                if (expected_outputs.size() == 0) begin
                    $error("unexpected output beat: filtered_value %h, verdict %0d",
                           m_tdata, m_tuser);
                    fail_count++;
                end else begin
                    head = expected_outputs.pop_front();
                    if (m_tdata !== head.value) begin
                        $error("filtered_value: expected %h, got %h", head.value, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser !== head.verdict) begin
                        $error("verdict: expected %0d, got %0d", head.verdict, m_tuser);
                        fail_count++;
                    end
                end
            end
            if (stall_requests != stalls_started) begin
                stalls_started = stall_requests;
                hold_left = StallCycles;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || $urandom_range(0, 99) >= 27;
            end
        end
    end

    task automatic send_sample(input logic [31:0] x);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < 27) begin
            gap = $urandom_range(1, 4);
        end
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= x;
        do @(posedge aclk); while (!s_tready);
        predict_filter(x);
        samples_sent++;
    endtask

    task automatic apb_access(input logic write, input logic [1:0] index,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= {index, 2'b00};
        pwdata <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        logic [31:0] unused;
        apb_access(1'b1, index, value, unused);
        case (index)
            REG_ACCEPT_COUNT_LIMIT:   cfg_accept_limit = value[15:0];
            REG_DISTANCE_LIMIT:       cfg_threshold = value[30:0];
            REG_STEP_AMPLITUDE_LIMIT: cfg_step_limit = value[30:0];
            REG_WARNING_COUNT_LIMIT:  cfg_warn_limit = value[15:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_outputs.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic configure(input logic [15:0] accept_limit, input logic [30:0] threshold,
                             input logic [30:0] step_limit, input logic [15:0] warn_limit);
        wait_drained();
        write_register(REG_ACCEPT_COUNT_LIMIT, {16'h0, accept_limit});
        write_register(REG_DISTANCE_LIMIT, {1'b0, threshold});
        write_register(REG_STEP_AMPLITUDE_LIMIT, {1'b0, step_limit});
        write_register(REG_WARNING_COUNT_LIMIT, {16'h0, warn_limit});
        settings_used++;
    endtask

    task automatic test_register_access();
        logic [1:0]  index;
        logic [31:0] mask;
        logic [31:0] readback;
        for (int i = 0; i < 4; i++) begin
            index = 2'(i);
            mask = (index == REG_DISTANCE_LIMIT || index == REG_STEP_AMPLITUDE_LIMIT) ?
                   32'h7FFF_FFFF : 32'h0000_FFFF;
            write_register(index, 32'hFFFF_FFFF);
            apb_access(1'b0, index, '0, readback);
            if (readback !== mask) begin
                $error("register %0d: expected %h, got %h", index, mask, readback);
                fail_count++;
            end
            write_register(index, 32'h0);
            apb_access(1'b0, index, '0, readback);
            if (readback !== 32'h0) begin
                $error("register %0d: expected %h, got %h", index, 32'h0, readback);
                fail_count++;
            end
        end
    endtask

    task automatic test_pass_through();
        configure(16'h0, 31'h0, 31'h0, 16'h0);
        send_sample(32'h0000_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0000_0001);
    endtask

    task automatic test_spike_and_step();
        configure(16'd3, 31'h1_0000, 31'h8000, 16'd3);
        send_sample(32'h0000_0000);
        send_sample(32'h0001_0000);
        send_sample(32'h0000_0000);
        send_sample(32'h0005_0000);
        send_sample(32'h0000_0000);
        send_sample(32'h0020_0000);
        send_sample(32'h0020_4000);
        send_sample(32'h001F_C000);
        send_sample(32'h0020_0000);
        send_sample(32'h0060_0000);
        send_sample(32'h00A0_0000);
        send_sample(32'h00A0_0000);
        send_sample(32'h00A0_0000);
        send_sample(32'h00A0_0000);
    endtask

    task automatic test_extreme_distances();
        configure(16'hFFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'h0);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'h8000_0000);
    endtask

    task automatic test_random_streams();
        logic [15:0] accept_limit;
        logic [15:0] warn_limit;
        logic [30:0] threshold;
        logic [30:0] step_limit;
        logic [31:0] level;
        int          pick;
        int          target;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    accept_limit = 16'hFFFF;
                    threshold = 31'h7FFF_FFFF;
                    step_limit = 31'h7FFF_FFFF;
                    warn_limit = 16'hFFFF;
                end
                1: begin
                    accept_limit = 16'h0;
                    threshold = 31'h0;
                    step_limit = 31'h0;
                    warn_limit = 16'h0;
                end
                default: begin
                    pick = $urandom_range(0, 4);
                    accept_limit = (pick == 0) ? 16'h0 :
                                   (pick == 4) ? 16'hFFFF : 16'($urandom_range(1, 6));
                    threshold = ($urandom_range(0, 3) == 0) ? 31'($urandom()) :
                                31'($urandom_range(0, 32'h4_0000));
                    step_limit = ($urandom_range(0, 3) == 0) ? 31'($urandom()) :
                                 31'($urandom_range(0, 32'h2_0000));
                    pick = $urandom_range(0, 4);
                    warn_limit = (pick == 0) ? 16'h0 :
                                 (pick == 4) ? 16'hFFFF : 16'($urandom_range(1, 8));
                end
            endcase
            configure(accept_limit, threshold, step_limit, warn_limit);
            calm = (phase == 3);
            if (phase == 5) begin
                stall_requests++;
            end
            target = samples_sent + 125;
            while (samples_sent < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    send_sample(held_value + signed_offset(cfg_threshold));
                end else if (pick < 65) begin
                    send_sample(held_value + $urandom());
                end else if (pick < 85) begin
                    level = held_value + ($urandom_range(0, 1) ?
                            {1'b0, cfg_threshold} + $urandom_range(1, 32'hFFFF) :
                            -({1'b0, cfg_threshold} + $urandom_range(1, 32'hFFFF)));
                    repeat ($urandom_range(1, 8)) begin
                        send_sample(level + signed_offset(cfg_step_limit >> 1));
                    end
                end else if (pick < 95) begin
                    send_sample($urandom());
                end else begin
                    case ($urandom_range(0, 3))
                        0: send_sample(32'h7FFF_FFFF);
                        1: send_sample(32'h8000_0000);
                        2: send_sample(32'hFFFF_FFFF);
                        default: send_sample(32'h0000_0000);
                    endcase
                end
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_register_access();
        test_pass_through();
        test_spike_and_step();
        test_extreme_distances();
        test_random_streams();
        wait_drained();
        repeat (5) @(posedge aclk);
        $display("Sent %0d samples under %0d register settings, with idle gaps and a long stall.",
                 samples_sent, settings_used);
        $display("Checked %0d results: %0d accepted, %0d rejected, %0d warnings.",
                 results_checked, verdict_count[0], verdict_count[1], verdict_count[2]);
        if (fail_count == 0) begin
            $display("tb_spike_rejection_filter passed");
        end else begin
            $display("tb_spike_rejection_filter failed");
        end
        $finish;
    end

endmodule
